// ===== design/wsde_pkg.sv =====
// Shared types and constants of the WS2812 dither bit encoder.
package wsde_pkg;

   localparam int unsigned SLOTS_PER_LED = 24;
   localparam int unsigned SLOT_W        = 5;
   localparam int unsigned BYTES_PER_LED = 3;
   localparam int unsigned SADDR_W       = 11;
   localparam int unsigned CODE_W        = 16;
   localparam int unsigned GAMMA_DEPTH   = 256;
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned LED_W         = 6;
   localparam int unsigned REQ_DATA_W    = 64;
   localparam int unsigned RSP_DATA_W    = 32;
   localparam int unsigned CSR_INDEX_W   = 1;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_LED - 1);
   localparam logic [1:0]        FETCH_END = 2'(BYTES_PER_LED);
   localparam logic [7:0]        GREY_MAX  = 8'd255;

   localparam logic [CODE_W-1:0] ONE_CODE_RESET  = 16'd76;
   localparam logic [CODE_W-1:0] ZERO_CODE_RESET = 16'd38;

   localparam logic [CSR_INDEX_W-1:0] REG_ONE_CODE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_CODE = 1'b1;

   typedef enum logic [1:0] {
      ACT_GAMMA = 2'd0,
      ACT_COLOR = 2'd1,
      ACT_GREY  = 2'd2
   } action_type;

   // Ordered dither thresholds, row-major over the 8x8 tile.
   localparam logic [5:0] BAYER_8X8 [64] = '{
      6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
      6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
      6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
      6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
      6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
      6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
      6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
      6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
   };

endpackage

// ===== design/wsde_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module wsde_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ws2812_dither_bit_encoder_core.sv =====
// Top level of the WS2812 bit encoder with gamma table and ordered dither.
//
// Requests arrive on the req_ stream; req_tuser carries the action. A gamma
// write stores one table entry in the cycle of its transfer and yields no
// result. A color or dithered gray request yields 24 slot transfers on the
// rsp_ stream, green, red, blue, most significant bit first; rsp_tlast marks
// the 24th. Unused actions and LEDs beyond LED_COUNT are taken and dropped.
// The csr_ port sets the one and zero compare codes; write it while idle.
//
// The gamma table sits in one RAM with a single read port. A fetch stage reads
// the three table bytes of a request one after another, then hands them to the
// emit stage, which sends one slot per cycle while the receiver is ready. The
// fetch of the next request overlaps the emission of the current one, so the
// block takes a new request while the last is still being sent; throughput is
// bounded by the single result port.
//
// Reset clears the stage valid flags and restores the default codes; the
// gamma table is not cleared and must be loaded before use. When the receiver
// stalls, the current slot holds, and one further request is fetched and
// parked; after that req_tready stays low until the emit stage frees up.
module ws2812_dither_bit_encoder_core
   import wsde_pkg::*;
#(
   parameter int unsigned LED_COUNT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata, lowest bit up: entry_index[7:0], entry_value[15:8],
   // led_pos[21:16], green[29:22], red[37:30], blue[45:38],
   // grey_level[59:46], zero fill[63:60].
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // tuser: action[1:0].
   input  logic [1:0]             req_tuser,
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata, lowest bit up: slot_address[10:0], pulse_code[26:11],
   // zero fill[31:27].
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CODE_W-1:0]      csr_wdata
);

   // Request fields.
   logic [7:0]  entry_index;
   logic [7:0]  entry_value;
   logic [5:0]  led_pos;
   logic [7:0]  green;
   logic [7:0]  red;
   logic [7:0]  blue;
   logic [13:0] grey_level;

   assign entry_index = req_tdata[7:0];
   assign entry_value = req_tdata[15:8];
   assign led_pos     = req_tdata[21:16];
   assign green       = req_tdata[29:22];
   assign red         = req_tdata[37:30];
   assign blue        = req_tdata[45:38];
   assign grey_level  = req_tdata[59:46];

   // Compare code registers.
   logic [CODE_W-1:0] one_code_ff;
   logic [CODE_W-1:0] zero_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_code_ff  <= ONE_CODE_RESET;
         zero_code_ff <= ZERO_CODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ONE_CODE:  one_code_ff  <= csr_wdata;
            REG_ZERO_CODE: zero_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Fetch stage: holds one request while its three gamma bytes are read.
   logic                    a_valid_ff, a_valid_in;
   logic [1:0]              a_cnt_ff, a_cnt_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [1:0]              rd_sel_ff, rd_sel_in;
   logic [2:0][BYTE_W-1:0]  a_idx_ff, a_idx_in;
   logic [2:0][BYTE_W-1:0]  a_byte_ff, a_byte_in;
   logic [SADDR_W-1:0]      a_base_ff, a_base_in;

   // Emit stage: shifts out the 24 bits of one LED.
   logic                      b_valid_ff, b_valid_in;
   logic [SLOTS_PER_LED-1:0]  b_bits_ff, b_bits_in;
   logic [SADDR_W-1:0]        b_addr_ff, b_addr_in;
   logic [SLOT_W-1:0]         b_cnt_ff, b_cnt_in;

   logic              req_xfer;
   logic              rsp_xfer;
   logic              in_range;
   logic              is_write;
   logic              is_fetch;
   logic              a_done;
   logic              b_last;
   logic              b_free;
   logic              load;
   logic              rd_en;
   logic [BYTE_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic [7:0]        grey_base;
   logic [7:0]        grey;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign in_range = 32'(led_pos) < LED_COUNT;

   always_comb begin
      is_write = 1'b0;
      is_fetch = 1'b0;
      case (req_tuser)
         ACT_GAMMA: is_write = req_xfer;
         ACT_COLOR: is_fetch = req_xfer && in_range;
         ACT_GREY:  is_fetch = req_xfer && in_range;
         default: ;
      endcase
   end

   // Dither: step up one gray level when the fraction beats the threshold.
   assign grey_base = grey_level[13:6];
   always_comb begin
      grey = grey_base;
      if ((grey_level[5:0] > BAYER_8X8[led_pos]) && (grey_base != GREY_MAX)) begin
         grey = grey_base + 8'd1;
      end
   end

   assign a_done = a_valid_ff && (a_cnt_ff == FETCH_END) && !rd_pend_ff;
   assign b_last = (b_cnt_ff == SLOT_LAST);
   assign b_free = !b_valid_ff || (rsp_xfer && b_last);
   assign load   = a_done && b_free;

   // A new request is taken once the fetch stage is empty or handing over,
   // so a table write never races a read of an earlier request.
   assign req_tready = !a_valid_ff || load;

   assign rd_en = a_valid_ff && (a_cnt_ff != FETCH_END);

   always_comb begin
      case (a_cnt_ff)
         2'd0:    rd_addr = a_idx_ff[0];
         2'd1:    rd_addr = a_idx_ff[1];
         default: rd_addr = a_idx_ff[2];
      endcase
   end

   wsde_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (GAMMA_DEPTH)
   ) u_gamma_ram (
      .clock   (clock),
      .wr_en   (is_write),
      .wr_addr (entry_index),
      .wr_data (entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      a_valid_in = a_valid_ff;
      a_cnt_in   = a_cnt_ff;
      a_idx_in   = a_idx_ff;
      a_base_in  = a_base_ff;
      a_byte_in  = a_byte_ff;
      rd_pend_in = rd_en;
      rd_sel_in  = a_cnt_ff;
      if (rd_en) begin
         a_cnt_in = a_cnt_ff + 2'd1;
      end
      if (rd_pend_ff) begin
         case (rd_sel_ff)
            2'd0:    a_byte_in[2] = rd_data;
            2'd1:    a_byte_in[1] = rd_data;
            default: a_byte_in[0] = rd_data;
         endcase
      end
      if (is_fetch) begin
         a_valid_in = 1'b1;
         a_cnt_in   = 2'd0;
         a_base_in  = SADDR_W'(led_pos) * SADDR_W'(SLOTS_PER_LED);
         if (req_tuser == ACT_COLOR) begin
            a_idx_in = {blue, red, green};
         end else begin
            a_idx_in = {grey, grey, grey};
         end
      end else if (load) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_bits_in  = b_bits_ff;
      b_addr_in  = b_addr_ff;
      b_cnt_in   = b_cnt_ff;
      if (load) begin
         b_valid_in = 1'b1;
         b_bits_in  = a_byte_ff;
         b_addr_in  = a_base_ff;
         b_cnt_in   = '0;
      end else if (rsp_xfer) begin
         if (b_last) begin
            b_valid_in = 1'b0;
         end
         b_bits_in = {b_bits_ff[SLOTS_PER_LED-2:0], 1'b0};
         b_addr_in = b_addr_ff + SADDR_W'(1);
         b_cnt_in  = b_cnt_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_cnt_ff   <= '0;
         rd_pend_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         b_cnt_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         a_cnt_ff   <= a_cnt_in;
         rd_pend_ff <= rd_pend_in;
         b_valid_ff <= b_valid_in;
         b_cnt_ff   <= b_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_sel_ff <= rd_sel_in;
      a_idx_ff  <= a_idx_in;
      a_byte_ff <= a_byte_in;
      a_base_ff <= a_base_in;
      b_bits_ff <= b_bits_in;
      b_addr_ff <= b_addr_in;
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tlast  = b_last;
   assign rsp_tdata  = {(RSP_DATA_W - CODE_W - SADDR_W)'(0),
                        (b_bits_ff[SLOTS_PER_LED-1] ? one_code_ff : zero_code_ff),
                        b_addr_ff};

`ifndef ASSERT_OFF
   // A table write never lands while a fetch is reading the table.
   a_no_write_during_fetch: assert property (@(posedge clock) disable iff (reset)
      is_write |-> !rd_en)
      else $error("gamma write overlaps a table read");

   // An LED is not cut short: after a slot that is not the last, another follows.
   a_led_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_tlast) |=> rsp_tvalid)
      else $error("slot run ended before its last slot");

   // Slot addresses within an LED step by one.
   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_tlast) |=> (b_addr_ff == $past(b_addr_ff) + SADDR_W'(1)))
      else $error("slot address did not advance by one");

   // An accepted encode request starts its fetch in the next cycle.
   a_fetch_starts: assert property (@(posedge clock) disable iff (reset)
      is_fetch |=> (a_valid_ff && (a_cnt_ff == 2'd0) && rd_en))
      else $error("fetch did not start after request transfer");
`endif

endmodule
